### design/divisor_sum_product_matcher_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the divisor sum/product matcher
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef DIVISOR_SUM_PRODUCT_MATCHER_UNIT_ASSERT_SVH
`define DIVISOR_SUM_PRODUCT_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define DSPM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSPM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dspm_pkg.sv
// ----------------------------------------------------------------------------
// dspm_pkg
// Widths and constants of the divisor sum/product matcher.
// ----------------------------------------------------------------------------
package dspm_pkg;

    localparam int VALUE_WIDTH = 16;        // bits of the input value examined
    localparam int VIN_W       = 16;        // input field width
    localparam int DSUM_W      = 20;        // output sum field width
    localparam int PROD_W      = 32;
    localparam int CNT_W       = 32;
    localparam int TGT_W       = 32;

    // trial divisor runs up to 2^ceil(W/2)
    localparam int D_W  = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_W = 2 * D_W;

    // divider retires DIV_STEPS quotient bits per cycle
    localparam int DIV_STEPS = 8;
    localparam int DIV_CYC   = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W     = DIV_CYC * DIV_STEPS;
    localparam int CYC_W     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    // sigma(n) < 8n over the whole range
    localparam int SUM_W = (VALUE_WIDTH + 3 > DSUM_W) ? VALUE_WIDTH + 3 : DSUM_W;
    localparam int CMP_W = (SUM_W > TGT_W) ? SUM_W : TGT_W;

    localparam logic [DSUM_W-1:0] DSUM_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

endpackage

### design/dspm_operand_if.sv
// ----------------------------------------------------------------------------
// dspm_operand_if
// Input channel: one value per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dspm_operand_if;
    import dspm_pkg::*;

    logic             valid;
    logic             ready;
    logic [VIN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### design/dspm_result_if.sv
// ----------------------------------------------------------------------------
// dspm_result_if
// Result channel: divisor sum, product, match flags and counters.
// ----------------------------------------------------------------------------
interface dspm_result_if;
    import dspm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [DSUM_W-1:0]        divisor_sum;
    logic signed [PROD_W-1:0] divisor_product;
    logic                     sum_matched;
    logic                     product_matched;
    logic [CNT_W-1:0]         sum_match_count;
    logic [CNT_W-1:0]         product_match_count;
    logic [CNT_W-1:0]         total_match_count;

    modport source (
        output valid, output divisor_sum, output divisor_product,
        output sum_matched, output product_matched,
        output sum_match_count, output product_match_count, output total_match_count,
        input  ready
    );
    modport sink (
        input  valid, input divisor_sum, input divisor_product,
        input  sum_matched, input product_matched,
        input  sum_match_count, input product_match_count, input total_match_count,
        output ready
    );
endinterface

### design/divisor_sum_product_matcher_unit.sv
// ----------------------------------------------------------------------------
// divisor_sum_product_matcher_unit
// Trial-division divisor sum and product with match counters.
// ----------------------------------------------------------------------------
// Usage:
//   operand: one value per item (valid/ready). Ready is high only while the
//     sequencer is idle; one item is worked on at a time.
//   result:  one item per input: sum (saturated to 20 bits), product (mod
//     2^32, signed), match flags and the three saturating counters after it.
//   cfg_write/cfg_data: load match_target; write only while idle.
// Sequence: each trial divisor d passes through the check, divide and accumulate
//   states in turn (the shared divider retires 8 quotient bits a cycle). Result
//   valid rises after the last divisor once the output register is free, and the
//   next item can be accepted from idle after that. The divider loop sets the rate.
// The result sits in an output register; the next item is accepted while it
//   waits. A stalled receiver holds the result and the finished item waits
//   in its last state, so no result is dropped.
// Reset clears the sequencer, the counters, the target and result valid.
// ----------------------------------------------------------------------------
module divisor_sum_product_matcher_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    dspm_operand_if.sink               operand,
    dspm_result_if.source              result,
    input  logic                       cfg_write,
    input  logic [dspm_pkg::TGT_W-1:0] cfg_data
);
    import dspm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_ACC   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [TGT_W-1:0]        target_reg;
    logic [VALUE_WIDTH-1:0]  v_reg;
    logic [D_W-1:0]          d_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DIV_W-1:0]        div_reg, div_next;
    logic [D_W-1:0]          rem_reg, rem_next;
    logic [CYC_W-1:0]        cyc_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [CNT_W-1:0]        sum_hits_reg, prod_hits_reg, all_hits_reg;

    logic                    res_valid_reg;
    logic [DSUM_W-1:0]       res_sum_reg;
    logic [PROD_W-1:0]       res_prod_reg;
    logic                    res_shit_reg, res_phit_reg;

    // ---- shared divider step: DIV_STEPS restoring steps ----
    always_comb
    begin
        logic [D_W:0] trial;
        rem_next = rem_reg;
        div_next = div_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial    = {rem_next, div_next[DIV_W-1]};
            div_next = {div_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                trial       = trial - {1'b0, d_reg};
                div_next[0] = 1'b1;
            end
            rem_next = trial[D_W-1:0];
        end
    end

    // ---- accumulate ----
    logic [VALUE_WIDTH-1:0]        quot;
    logic                          not_sq;
    logic [VALUE_WIDTH-1:0]        factor;
    logic [PROD_W+VALUE_WIDTH-1:0] mul_full;
    logic [SUM_W-1:0]              sum_acc;

    assign quot     = div_reg[VALUE_WIDTH-1:0];
    assign not_sq   = (sq_reg != SQ_W'(v_reg));
    // d*q == v, so a divisor pair multiplies in v at once
    assign factor   = not_sq ? v_reg : VALUE_WIDTH'(d_reg);
    assign mul_full = prod_reg * factor;
    assign sum_acc  = sum_reg + SUM_W'(d_reg) + (not_sq ? SUM_W'(quot) : SUM_W'(0));

    // ---- match and counters ----
    logic             s_hit, p_hit, out_free;
    logic [CNT_W-1:0] all_mid, all_fin;

    assign s_hit    = !target_reg[TGT_W-1] && (CMP_W'(sum_reg) == CMP_W'(target_reg));
    assign p_hit    = (prod_reg == target_reg);
    assign all_mid  = (s_hit && all_hits_reg != CNT_MAX) ? all_hits_reg + 1'b1 : all_hits_reg;
    assign all_fin  = (p_hit && all_mid != CNT_MAX) ? all_mid + 1'b1 : all_mid;
    assign out_free = !res_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (operand.valid) state_next = ST_CHECK;
            ST_CHECK: state_next = (sq_reg > SQ_W'(v_reg)) ? ST_DONE : ST_DIV;
            ST_DIV:   if (cyc_reg == '0) state_next = ST_ACC;
            ST_ACC:   state_next = ST_CHECK;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            sum_hits_reg  <= '0;
            prod_hits_reg <= '0;
            all_hits_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
                target_reg <= cfg_data;
            if (state_reg == ST_DONE && out_free)
            begin
                res_valid_reg <= 1'b1;
                if (s_hit && sum_hits_reg != CNT_MAX)
                    sum_hits_reg <= sum_hits_reg + 1'b1;
                if (p_hit && prod_hits_reg != CNT_MAX)
                    prod_hits_reg <= prod_hits_reg + 1'b1;
                all_hits_reg <= all_fin;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                v_reg    <= VALUE_WIDTH'(operand.value);
                d_reg    <= D_W'(1);
                sq_reg   <= SQ_W'(1);
                sum_reg  <= '0;
                prod_reg <= PROD_W'(1);
            end
            ST_CHECK:
            begin
                div_reg <= DIV_W'(v_reg);
                rem_reg <= '0;
                cyc_reg <= CYC_W'(DIV_CYC - 1);
            end
            ST_DIV:
            begin
                div_reg <= div_next;
                rem_reg <= rem_next;
                cyc_reg <= cyc_reg - 1'b1;
            end
            ST_ACC:
            begin
                if (rem_reg == '0)
                begin
                    sum_reg  <= sum_acc;
                    prod_reg <= mul_full[PROD_W-1:0];
                end
                d_reg  <= d_reg + 1'b1;
                sq_reg <= sq_reg + SQ_W'({d_reg, 1'b1});
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_sum_reg  <= (SUM_W'(DSUM_MAX) < sum_reg) ? DSUM_MAX
                                                                 : sum_reg[DSUM_W-1:0];
                    res_prod_reg <= prod_reg;
                    res_shit_reg <= s_hit;
                    res_phit_reg <= p_hit;
                end
            end
            default:
            begin
                v_reg <= v_reg;
            end
        endcase
    end

    assign operand.ready              = (state_reg == ST_IDLE);
    assign result.valid               = res_valid_reg;
    assign result.divisor_sum         = res_sum_reg;
    assign result.divisor_product     = res_prod_reg;
    assign result.sum_matched         = res_shit_reg;
    assign result.product_matched     = res_phit_reg;
    assign result.sum_match_count     = sum_hits_reg;
    assign result.product_match_count = prod_hits_reg;
    assign result.total_match_count   = all_hits_reg;

endmodule

### design/dspm_checker.sv
// ----------------------------------------------------------------------------
// dspm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "divisor_sum_product_matcher_unit_assert.svh"

module dspm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        op_valid,
    input logic                        op_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [dspm_pkg::DSUM_W-1:0] res_sum,
    input logic [dspm_pkg::PROD_W-1:0] res_prod,
    input logic                        res_shit,
    input logic [dspm_pkg::CNT_W-1:0]  res_scnt,
    input logic [dspm_pkg::CNT_W-1:0]  res_tcnt
);
    import dspm_pkg::*;

    // stalled result holds
    `DSPM_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_sum) && $stable(res_prod), "result changed under stall")

    // one item at a time: busy right after accept
    `DSPM_ASSERT_NXT(a_busy, clk, rst_n, op_valid && op_ready, !op_ready,
        "operand accepted while busy")

    `DSPM_ASSERT_IMP(a_hit_count, clk, rst_n, res_valid && res_shit, res_scnt != '0,
        "sum match not counted")

    // total counts every sum match too
    `DSPM_ASSERT_IMP(a_total_ge, clk, rst_n, res_valid, res_tcnt >= res_scnt,
        "total count below sum count")

endmodule

bind divisor_sum_product_matcher_unit dspm_checker u_dspm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (operand.valid),
    .op_ready  (operand.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_sum   (result.divisor_sum),
    .res_prod  (result.divisor_product),
    .res_shit  (result.sum_matched),
    .res_scnt  (result.sum_match_count),
    .res_tcnt  (result.total_match_count)
);
